// ===== rtl/core/hssd_pkg.sv =====
package hssd_pkg;

    localparam int NUM_CHANNELS_DEF       = 4;
    localparam int OPEN_TRIGGER_TICKS_DEF = 4;
    localparam int TIMEOUT_TICKS_DEF      = 20;

    localparam int CFG_AW = 4;

    // register indexes (word address)
    localparam logic [1:0] REG_OPEN_MA     = 2'd0;
    localparam logic [1:0] REG_OVERLOAD_MA = 2'd1;
    localparam logic [1:0] REG_STUCK_MV    = 2'd2;

    localparam logic [15:0] OPEN_MA_RST     = 16'd50;
    localparam logic [15:0] OVERLOAD_MA_RST = 16'd2500;
    localparam logic [15:0] STUCK_MV_RST    = 16'd2000;

    localparam logic [1:0] OP_OFF    = 2'd0;
    localparam logic [1:0] OP_ON     = 2'd1;
    localparam logic [1:0] OP_CHECK  = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [2:0] STAT_OFF       = 3'd0;
    localparam logic [2:0] STAT_ON        = 3'd1;
    localparam logic [2:0] STAT_OPEN_PEND = 3'd2;
    localparam logic [2:0] STAT_OPEN_CONF = 3'd3;
    localparam logic [2:0] STAT_TIMEOUT   = 3'd4;

    typedef enum logic [1:0] {
        MODE_OFF     = 2'd0,
        MODE_ON      = 2'd1,
        MODE_OPEN    = 2'd2,
        MODE_TIMEOUT = 2'd3
    } t_mode;

    typedef struct packed {
        t_mode      mode;
        logic [7:0] ticks;
        logic       drive;
        logic       req;
        logic       f_open;
        logic       f_ovl;
        logic       f_stuck;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic [15:0] open_ma;
        logic [15:0] ovl_ma;
        logic [15:0] stuck_mv;
    } t_cfg;

    function automatic t_entry step_entry(
        input t_entry      cur,
        input logic [1:0]  op,
        input logic [15:0] mv,
        input logic [15:0] ma,
        input t_cfg        cfg,
        input logic [7:0]  open_ticks,
        input logic [7:0]  timeout_ticks
    );
        t_entry e;
        e = cur;
        case (op)
            OP_OFF: begin
                e.mode  = MODE_OFF;
                e.drive = 1'b0;
                e.req   = 1'b0;
            end
            OP_ON: begin
                if (e.mode == MODE_OFF) begin
                    e.drive = 1'b1;
                    e.mode  = MODE_ON;
                end
                e.req = 1'b1;
            end
            OP_CHECK: begin
                case (e.mode)
                    MODE_ON: begin
                        if (ma < cfg.open_ma) begin
                            e.mode  = MODE_OPEN;
                            e.ticks = '0;
                        end
                    end
                    MODE_OPEN: begin
                        if (e.ticks < open_ticks) begin
                            e.ticks = e.ticks + 8'd1;
                        end else begin
                            e.f_open = 1'b1;
                        end
                    end
                    MODE_TIMEOUT: begin
                        if (e.ticks < timeout_ticks) begin
                            e.ticks = e.ticks + 8'd1;
                        end else begin
                            e.mode  = MODE_ON;
                            e.drive = 1'b1;
                        end
                    end
                    default: ;
                endcase
                if (e.mode == MODE_OFF) begin
                    e.f_stuck = (mv > cfg.stuck_mv);
                end else begin
                    // load present restores on, even out of timeout
                    if (ma > cfg.open_ma) begin
                        e.mode   = MODE_ON;
                        e.f_open = 1'b0;
                    end
                    if (ma > cfg.ovl_ma) begin
                        e.f_ovl = 1'b1;
                        e.drive = 1'b0;
                        e.mode  = MODE_TIMEOUT;
                        e.ticks = '0;
                    end else begin
                        e.f_ovl = 1'b0;
                    end
                end
            end
            default: ;
        endcase
        return e;
    endfunction

    function automatic logic [2:0] status_of(input t_entry e, input logic [7:0] open_ticks);
        logic [2:0] s;
        case (e.mode)
            MODE_ON:      s = STAT_ON;
            MODE_OPEN:    s = (e.ticks >= open_ticks) ? STAT_OPEN_CONF : STAT_OPEN_PEND;
            MODE_TIMEOUT: s = STAT_TIMEOUT;
            default:      s = STAT_OFF;
        endcase
        return s;
    endfunction

endpackage

// ===== rtl/core/hssd_ram.sv =====
module hssd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                                         i_clk,
    input  logic                                         i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                             i_wdata,
    input  logic                                         i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                             o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // read returns the old contents on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/hssd_cfg.sv =====
module hssd_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [hssd_pkg::CFG_AW-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output hssd_pkg::t_cfg              o_cfg
);
    import hssd_pkg::*;

    t_cfg       r_cfg;
    logic [1:0] w_idx;
    logic       w_wr;

    assign w_idx  = paddr[3:2];
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.open_ma  <= OPEN_MA_RST;
            r_cfg.ovl_ma   <= OVERLOAD_MA_RST;
            r_cfg.stuck_mv <= STUCK_MV_RST;
        end else if (w_wr) begin
            case (w_idx)
                REG_OPEN_MA:     r_cfg.open_ma  <= pwdata[15:0];
                REG_OVERLOAD_MA: r_cfg.ovl_ma   <= pwdata[15:0];
                REG_STUCK_MV:    r_cfg.stuck_mv <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_OPEN_MA:     prdata = {16'd0, r_cfg.open_ma};
            REG_OVERLOAD_MA: prdata = {16'd0, r_cfg.ovl_ma};
            REG_STUCK_MV:    prdata = {16'd0, r_cfg.stuck_mv};
            default:         prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/core/high_side_switch_diagnostics_unit.sv =====
// channel   direction  handshake                 payload
// cfg       in/out     psel/penable/pwrite/pready paddr, pwdata, prdata
// in        in         i_in_valid / o_in_stall    opcode, channel, sensed mv/ma
// out       out        o_out_valid / i_out_stall  echo, drive, request, status, faults
//
// one item per cycle sustained while the output is not stalled; s1 holds the memory
// read, then modify and write back load the result register, held until taken
// back-to-back items on one channel use a one-entry forward of the last write
// reset clears the per-channel valid bits at once: no clearing pass
// a stalled output stalls the update stage and the input behind it
module high_side_switch_diagnostics_unit #(
    parameter int NUM_CHANNELS       = hssd_pkg::NUM_CHANNELS_DEF,
    parameter int OPEN_TRIGGER_TICKS = hssd_pkg::OPEN_TRIGGER_TICKS_DEF,
    parameter int TIMEOUT_TICKS      = hssd_pkg::TIMEOUT_TICKS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [hssd_pkg::CFG_AW-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [1:0]                  i_opcode,
    input  logic [1:0]                  i_channel,
    input  logic [15:0]                 i_sensed_mv,
    input  logic [15:0]                 i_sensed_ma,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [1:0]                  o_channel_echo,
    output logic                        o_drive_on,
    output logic                        o_requested_on,
    output logic [2:0]                  o_channel_status,
    output logic                        o_fault_open,
    output logic                        o_fault_overload,
    output logic                        o_fault_stuck
);
    import hssd_pkg::*;

    localparam int AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam logic [7:0] OPEN_T = 8'(OPEN_TRIGGER_TICKS);
    localparam logic [7:0] TMO_T  = 8'(TIMEOUT_TICKS);

    t_cfg w_cfg;

    hssd_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    logic              w_in_acc;
    logic              w_adv;
    logic [2:0]        w_in_ext;
    logic [AW-1:0]     w_raddr;

    logic              r_s1_valid;
    logic [1:0]        r_s1_op;
    logic [1:0]        r_s1_ch;
    logic [15:0]       r_s1_mv;
    logic [15:0]       r_s1_ma;
    logic [2:0]        w_s1_ext;
    logic [AW-1:0]     w_s1_addr;
    logic              w_s1_inr;

    logic [ENTRY_W-1:0] w_rdata;
    logic [(1<<AW)-1:0] r_vld;
    logic               r_fwd_valid;
    logic [AW-1:0]      r_fwd_addr;
    t_entry             r_fwd_data;
    t_entry             w_cur;
    t_entry             w_nxt;
    logic               w_we;

    logic              r_out_valid;
    logic [1:0]        r_echo;
    logic              r_drive;
    logic              r_req;
    logic [2:0]        r_status;
    logic              r_f_open;
    logic              r_f_ovl;
    logic              r_f_stuck;

    assign w_adv      = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_s1_valid && !w_adv;
    assign w_in_acc   = i_in_valid && !o_in_stall;

    assign w_in_ext  = {1'b0, i_channel};
    assign w_raddr   = w_in_ext[AW-1:0];
    assign w_s1_ext  = {1'b0, r_s1_ch};
    assign w_s1_addr = w_s1_ext[AW-1:0];
    assign w_s1_inr  = ({2'b00, r_s1_ch} < 4'(NUM_CHANNELS));

    hssd_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_CHANNELS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_s1_addr),
        .i_wdata (w_nxt),
        .i_re    (w_in_acc),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // last write lands at the same edge as the next read: forward it
    always_comb begin
        if (r_fwd_valid && (r_fwd_addr == w_s1_addr)) begin
            w_cur = r_fwd_data;
        end else if (r_vld[w_s1_addr]) begin
            w_cur = t_entry'(w_rdata);
        end else begin
            w_cur = '0;
        end
    end

    assign w_nxt = step_entry(w_cur, r_s1_op, r_s1_mv, r_s1_ma, w_cfg, OPEN_T, TMO_T);
    assign w_we  = w_adv && w_s1_inr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_fwd_valid <= 1'b0;
            r_vld       <= '0;
        end else begin
            if (w_in_acc) begin
                r_s1_valid <= 1'b1;
            end else if (w_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (w_we) begin
                r_fwd_valid        <= 1'b1;
                r_vld[w_s1_addr]   <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_s1_op <= i_opcode;
            r_s1_ch <= i_channel;
            r_s1_mv <= i_sensed_mv;
            r_s1_ma <= i_sensed_ma;
        end
        if (w_we) begin
            r_fwd_addr <= w_s1_addr;
            r_fwd_data <= w_nxt;
        end
        if (w_adv) begin
            r_echo <= r_s1_ch;
            if (w_s1_inr) begin
                r_drive   <= w_nxt.drive;
                r_req     <= w_nxt.req;
                r_status  <= status_of(w_nxt, OPEN_T);
                r_f_open  <= w_nxt.f_open;
                r_f_ovl   <= w_nxt.f_ovl;
                r_f_stuck <= w_nxt.f_stuck;
            end else begin
                r_drive   <= 1'b0;
                r_req     <= 1'b0;
                r_status  <= STAT_OFF;
                r_f_open  <= 1'b0;
                r_f_ovl   <= 1'b0;
                r_f_stuck <= 1'b0;
            end
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_channel_echo   = r_echo;
    assign o_drive_on       = r_drive;
    assign o_requested_on   = r_req;
    assign o_channel_status = r_status;
    assign o_fault_open     = r_f_open;
    assign o_fault_overload = r_f_ovl;
    assign o_fault_stuck    = r_f_stuck;

endmodule
